@@ sv/b64d_pkg.sv @@
package b64d_pkg;

    // Result queue geometry: one quartet can push up to three bytes at once
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    localparam int MAX_PUSH   = 3;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic [5:0] value;
        logic       bad;
        logic       pad;
    } sextet_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       length_error;
        logic       bad_char;
    } result_t;

    function automatic sextet_t map_char(input logic [7:0] c);
        sextet_t s;
        s = '{value: 6'd0, bad: 1'b0, pad: 1'b0};
        priority if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            s.value = 6'(c - CHAR_UP_A);
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            s.value = 6'(c - CHAR_LO_A + 8'd26);
        end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            s.value = 6'(c - CHAR_DIG_0 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            s.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            s.value = SEXTET_SLASH;
        end else if (c == CHAR_PAD) begin
            s.pad = 1'b1;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

@@ sv/base64_stream_decoder.sv @@
// Base64 stream decoder.
// Slave channel: one ASCII character per transfer in s_tdata, s_tlast on the
// last character of the encoded text. Master channel: one decoded byte per
// transfer in m_tdata, m_tlast on the final byte of a message, m_tuser
// carrying the length-error and bad-character flags.
// A character is accepted every cycle while s_tready is high. The fourth
// character of a quartet pushes up to three bytes into an 8-entry result
// queue; the first is on m_tvalid in the next cycle if the queue was empty,
// the rest follow one per cycle while m_tready is high. A final flag on an
// incomplete quartet pushes a single result, data 0, length-error flag set.
// Throughput: four characters in, three bytes out, so the queue keeps up
// with an input transfer every cycle and an output transfer every cycle.
// s_tready is high whenever the queue has room for three results; it drops
// only when m_tready is held low until more than five results are queued,
// and results are held, never dropped, while m_tready is low.
// Reset (aresetn low at a clock edge) empties the queue and clears the
// partial quartet.
module base64_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] length_error, [1] bad_char
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic        third_pad_reg, third_pad_next;
    logic        qbad_reg, qbad_next;

    logic                        s_fire;
    logic                        m_fire;
    b64d_pkg::sextet_t           sx;
    logic                        badq;
    logic [23:0]                 group;
    logic [1:0]                  push_n;
    logic [1:0]                  byte_cnt;
    b64d_pkg::result_t           push_data [b64d_pkg::MAX_PUSH];
    b64d_pkg::result_t           head;
    logic [b64d_pkg::CNT_W-1:0]  fill;

    assign s_tready = (fill <= b64d_pkg::CNT_W'(b64d_pkg::FIFO_DEPTH - b64d_pkg::MAX_PUSH));
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        sx    = b64d_pkg::map_char(s_tdata);
        badq  = qbad_reg | sx.bad;
        group = {acc_reg, sx.value};

        acc_next       = acc_reg;
        pos_next       = pos_reg;
        third_pad_next = third_pad_reg;
        qbad_next      = qbad_reg;
        push_n         = 2'd0;
        byte_cnt       = 2'd3;

        for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
            push_data[k] = '{data_byte: group[23 - 8*k -: 8], last_byte: 1'b0,
                             length_error: 1'b0, bad_char: badq};
        end

        if (s_fire) begin
            if (pos_reg != 2'd3) begin
                if (s_tlast) begin
                    // incomplete quartet: single error result, then start over
                    push_n       = 2'd1;
                    push_data[0] = '{data_byte: 8'd0, last_byte: 1'b1,
                                     length_error: 1'b1, bad_char: badq};
                    acc_next       = '0;
                    pos_next       = 2'd0;
                    third_pad_next = 1'b0;
                    qbad_next      = 1'b0;
                end else begin
                    acc_next  = {acc_reg[11:0], sx.value};
                    pos_next  = pos_reg + 2'd1;
                    qbad_next = badq;
                    if (pos_reg == 2'd2) begin
                        third_pad_next = sx.pad;
                    end
                end
            end else begin
                // drop one byte per pad in the third and fourth place of the final quartet
                if (s_tlast) begin
                    byte_cnt = 2'd3 - 2'(sx.pad) - 2'(third_pad_reg);
                end
                push_n = byte_cnt;
                for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
                    push_data[k].last_byte = s_tlast && (2'(k + 1) == byte_cnt);
                end
                acc_next       = '0;
                pos_next       = 2'd0;
                third_pad_next = 1'b0;
                qbad_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            third_pad_reg <= 1'b0;
            qbad_reg      <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            third_pad_reg <= third_pad_next;
            qbad_reg      <= qbad_next;
        end
    end

    b64d_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_data (push_data),
        .pop       (m_fire),
        .head      (head),
        .fill      (fill)
    );

    assign m_tvalid = (fill != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = head.data_byte;
    assign m_tlast  = head.last_byte;
    assign m_tuser  = {head.bad_char, head.length_error};

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |->
            ({1'b0, fill} + 5'(push_n) <= 5'(b64d_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (pos_reg == 2'd0 && !qbad_reg && !third_pad_reg))
        else $error("quartet state not cleared after final character");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && m_tlast))
        else $error("length-error result malformed");

    a_push_only_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |-> (s_fire && (s_tlast || pos_reg == 2'd3)))
        else $error("result pushed without a completing character");
`endif

endmodule

@@ sv/b64d_fifo.sv @@
module b64d_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [1:0]                   push_n,
    input  b64d_pkg::result_t            push_data [b64d_pkg::MAX_PUSH],
    input  logic                         pop,
    output b64d_pkg::result_t            head,
    output logic [b64d_pkg::CNT_W-1:0]   fill
);

    b64d_pkg::result_t                store [b64d_pkg::FIFO_DEPTH];
    logic [b64d_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::CNT_W-1:0]       fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + b64d_pkg::PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + b64d_pkg::PTR_W'(pop);
        fill_next   = fill_reg + b64d_pkg::CNT_W'(push_n) - b64d_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < b64d_pkg::MAX_PUSH; k++) begin
            if (k < int'(push_n)) begin
                store[wr_ptr_reg + b64d_pkg::PTR_W'(k)] <= push_data[k];
            end
        end
    end

    assign head = store[rd_ptr_reg];
    assign fill = fill_reg;

endmodule

@@ verif/base64_stream_decoder_tb.sv @@
module base64_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       len_err;
        logic       bad;
    } decoded_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] data_byte
    logic       m_tlast;
    logic [1:0] m_tuser;            // [0] length_error, [1] bad_char

    char_item_t char_q[$];
    decoded_t   decoded_q[$];
    char_item_t tx_item;
    decoded_t   got_byte;
    decoded_t   want_byte;
    int         errors      = 0;
    int         tx_idle_pct = 24;
    int         rx_idle_pct = 52;

    // Decoder state mirrored from the quartet being gathered
    logic [17:0] q_acc       = '0;
    logic [1:0]  q_pos       = '0;
    logic        q_third_pad = 1'b0;
    logic        q_bad       = 1'b0;

    base64_stream_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Returns {bad, sextet}
    function automatic logic [6:0] lookup_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return {1'b0, 6'(c - 8'd65)};
        end else if (c >= "a" && c <= "z") begin
            return {1'b0, 6'(c - 8'd71)};
        end else if (c >= "0" && c <= "9") begin
            return {1'b0, 6'(c + 8'd4)};
        end else if (c == "+") begin
            return {1'b0, 6'd62};
        end else if (c == "/") begin
            return {1'b0, 6'd63};
        end else begin
            return {c != "=", 6'd0};
        end
    endfunction

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) begin
            return b64d_pkg::CHAR_UP_A + 8'(idx);
        end else if (idx < 52) begin
            return b64d_pkg::CHAR_LO_A + 8'(idx - 26);
        end else if (idx < 62) begin
            return b64d_pkg::CHAR_DIG_0 + 8'(idx - 52);
        end else if (idx == 62) begin
            return b64d_pkg::CHAR_PLUS;
        end else begin
            return b64d_pkg::CHAR_SLASH;
        end
    endfunction

    task automatic decode_char(input logic [7:0] code, input logic fin);
        logic [6:0]  lk;
        logic        pad;
        logic        badq;
        logic [23:0] grp;
        int          n;
        lk   = lookup_sextet(code);
        pad  = (code == b64d_pkg::CHAR_PAD);
        badq = q_bad | lk[6];
        if (q_pos != 2'd3) begin
            if (q_pos == 2'd2) q_third_pad = pad;
            q_acc = {q_acc[11:0], lk[5:0]};
            q_bad = badq;
            q_pos = q_pos + 2'd1;
            if (fin) begin
                decoded_q.push_back('{data: 8'h00, last: 1'b1, len_err: 1'b1, bad: badq});
                {q_acc, q_pos, q_third_pad, q_bad} = '0;
            end
        end else begin
            grp = {q_acc, lk[5:0]};
            n = 3;
            // drop one byte per pad in the third and fourth slot of the final quartet
            if (fin) n = 3 - int'(pad) - int'(q_third_pad);
            for (int k = 0; k < n; k++) begin
                decoded_q.push_back('{data: 8'(grp >> (16 - 8 * k)),
                                      last: fin && (k == n - 1),
                                      len_err: 1'b0, bad: badq});
            end
            {q_acc, q_pos, q_third_pad, q_bad} = '0;
        end
    endtask

    task automatic push_char(input logic [7:0] code, input logic fin);
        char_q.push_back('{code: code, fin: fin});
    endtask

    task automatic push_text(input string s, input logic fin_on_last);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], fin_on_last && (i == s.len() - 1));
        end
    endtask

    task automatic fill_random(input int n_items);
        int         added;
        int         nq;
        int         pads;
        int         len;
        int         r;
        logic [7:0] c;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                // well-formed message, possibly padded at the end
                nq   = $urandom_range(1, 3);
                pads = $urandom_range(0, 2);
                for (int i = 0; i < 4 * nq; i++) begin
                    c = alpha_char($urandom_range(0, 63));
                    if (i >= 4 * nq - pads) c = b64d_pkg::CHAR_PAD;
                    push_char(c, i == 4 * nq - 1);
                end
                added += 4 * nq;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 3);
                    if (r < 2) c = 8'($urandom_range(0, 255));
                    else if (r == 2) c = b64d_pkg::CHAR_PAD;
                    else c = alpha_char($urandom_range(0, 63));
                    push_char(c, (i == len - 1) && ($urandom_range(0, 1) == 1));
                end
                added += len;
            end
        end
    endtask

    task automatic wait_sent();
        do @(negedge aclk); while (char_q.size() != 0 || s_tvalid);
    endtask

    // Sender: advance to the next character once the current transfer is done
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                tx_item = char_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tx_item.code;
                s_tlast  <= tx_item.fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got_byte = '{data: m_tdata, last: m_tlast,
                             len_err: m_tuser[0], bad: m_tuser[1]};
                if (decoded_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected byte %h last=%b lerr=%b bad=%b", $realtime,
                                 got_byte.data, got_byte.last, got_byte.len_err, got_byte.bad);
                end else begin
                    want_byte = decoded_q.pop_front();
                    if (got_byte !== want_byte) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: exp %h l=%b e=%b b=%b, got %h l=%b e=%b b=%b",
                                     $realtime,
                                     want_byte.data, want_byte.last, want_byte.len_err,
                                     want_byte.bad, got_byte.data, got_byte.last,
                                     got_byte.len_err, got_byte.bad);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: alphabet edges, out-of-alphabet bytes, pads in every slot,
        // short finals with and without bad characters
        push_text("AZaz", 1'b0);
        push_text("09+/", 1'b1);
        push_char(8'h00, 1'b0);
        push_text("==", 1'b0);
        push_char(8'hFF, 1'b0);
        push_text("QQ==", 1'b1);
        push_text("=QQ=", 1'b1);
        push_text("Q", 1'b1);
        push_text("QQ~", 1'b1);
        fill_random(30);
        wait_sent();

        tx_idle_pct = 52;
        rx_idle_pct = 24;
        fill_random(45);
        wait_sent();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_random(45);
        // close any partial quartet left by noise
        push_text("QQ", 1'b1);
        wait_sent();

        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
